/* rtl/wipo_pkg.sv */
// Shared types, constants and tables for the wheel/heading pose tracker.
// No dependencies; used by wipo_engine and wheel_imu_pose_odometry.
package wipo_pkg;

   localparam int ANGLE_BITS   = 16;                 // angle resolution in bits of a half turn
   localparam int CORDIC_STEPS = 16;                 // CORDIC iterations, at most 24
   localparam int ANGLE_DROP   = 31 - ANGLE_BITS;    // low angle bits rounded away
   localparam int MUL_STEPS    = 32;                 // multiplier bits per product
   localparam int DIV_STEPS    = 72;                 // dividend bits per quotient
   localparam int CNT_W        = 7;
   localparam int CSR_IDX_W    = 2;

   localparam logic [31:0] PI_Q30       = 32'd3373259426;
   localparam logic [31:0] GAIN_Q30     = 32'd652032874;
   localparam logic [31:0] TRAVEL_DIV   = 32'd18000;
   localparam logic [31:0] TRAVEL_HALF  = 32'd9000;
   localparam logic [15:0] ARC_SCALE    = 16'd36000;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_OFS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_OFS = 2'd2;

   // atan(2^-i) in binary angle, 2^32 per turn; padded to a power of two
   localparam logic [31:0] ATAN_TURN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
   };

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_COR
   } op_type;

   typedef struct packed {
      logic        start;
      op_type      op;
      logic [71:0] a;      // multiplicand or dividend magnitude
      logic [31:0] b;      // multiplier, divisor or angle
      logic        neg;    // negate the result
   } eng_cmd_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] res;
      logic signed [33:0] cos_q30;
      logic signed [33:0] sin_q30;
   } eng_sts_type;

   typedef struct packed {
      logic               command;
      logic signed [31:0] forward_angle;
      logic signed [31:0] sideways_angle;
      logic        [15:0] heading;
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] position_x;
      logic signed [31:0] position_y;
      logic        [15:0] heading_now;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_TXMUL,
      ST_TXDIV,
      ST_TYMUL,
      ST_TYDIV,
      ST_ACOR,
      ST_AXDIV,
      ST_AXMUL,
      ST_AYDIV,
      ST_AYMUL,
      ST_MCOR,
      ST_G1,
      ST_G2,
      ST_G3,
      ST_G4,
      ST_DONE
   } st_type;

endpackage

/* rtl/wheel_imu_pose_odometry.sv */
// Operation: set_pose goes straight to the result; a tick, with or without a heading
//   change, runs on the serial multiplier, serial divider and 16-step CORDIC, all in
//   wipo_engine, used one operation at a time.
// Throughput: one transaction at a time; the next is taken once the result is in the
//   output register, even while that result still waits on rsp_stall.
// Reset (synchronous, active high): pose, wheel history and heading cleared; registers
//   back to radius 1.375 in, offsets 3.125 in and 5.35 in.
module wheel_imu_pose_odometry (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  wipo_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output wipo_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [wipo_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [11:0]                       csr_wdata
);
   import wipo_pkg::*;

   // control
   st_type state_ff, state_in;
   logic   run_ff, run_in;
   logic   rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // configuration
   logic [11:0] radius_ff, radius_in;
   logic [11:0] fwd_ofs_ff, fwd_ofs_in;
   logic [11:0] side_ofs_ff, side_ofs_in;

   // architectural state
   logic [31:0] last_fwd_ff, last_fwd_in;
   logic [31:0] last_side_ff, last_side_in;
   logic [15:0] last_head_ff, last_head_in;
   logic [31:0] gx_ff, gx_in;
   logic [31:0] gy_ff, gy_in;

   // per-transaction working values (two's complement)
   logic [31:0]        df_ff, df_in, ds_ff, ds_in;
   logic [15:0]        dh_ff, dh_in;
   logic [16:0]        mid_ff, mid_in;
   logic [63:0]        tmp_ff, tmp_in;
   logic [63:0]        dxl_ff, dxl_in, dyl_ff, dyl_in;
   logic signed [33:0] sh_ff, sh_in, cm_ff, cm_in, sm_ff, sm_in;

   eng_cmd_type cmd;
   eng_sts_type sts;

   logic        x_axis, d_neg, fin, is_op, accept;
   logic [31:0] d_mag, ud;
   logic [43:0] d_r;
   logic [15:0] dh_mag;
   logic [63:0] tmp_mag, dxl_mag, dyl_mag;
   logic [33:0] sh_abs, sm_abs, cm_abs;
   logic [31:0] sh2_mag;

   wipo_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   always_comb begin
      // operand magnitudes
      x_axis  = (state_ff == ST_TXMUL) || (state_ff == ST_TXDIV) || (state_ff == ST_AXDIV);
      d_neg   = x_axis ? ds_ff[31] : df_ff[31];
      d_mag   = x_axis ? (ds_ff[31] ? 32'd0 - ds_ff : ds_ff)
                       : (df_ff[31] ? 32'd0 - df_ff : df_ff);
      d_r     = 44'(d_mag) * 44'(radius_ff);
      dh_mag  = dh_ff[15] ? 16'd0 - dh_ff : dh_ff;
      ud      = 32'(dh_mag) * 32'(ARC_SCALE);
      tmp_mag = tmp_ff[63] ? 64'd0 - tmp_ff : tmp_ff;
      dxl_mag = dxl_ff[63] ? 64'd0 - dxl_ff : dxl_ff;
      dyl_mag = dyl_ff[63] ? 64'd0 - dyl_ff : dyl_ff;
      sh_abs  = sh_ff[33] ? 34'd0 - sh_ff : sh_ff;
      sm_abs  = sm_ff[33] ? 34'd0 - sm_ff : sm_ff;
      cm_abs  = cm_ff[33] ? 34'd0 - cm_ff : cm_ff;
      sh2_mag = {sh_abs[30:0], 1'b0};

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      radius_in    = radius_ff;
      fwd_ofs_in   = fwd_ofs_ff;
      side_ofs_in  = side_ofs_ff;
      last_fwd_in  = last_fwd_ff;
      last_side_in = last_side_ff;
      last_head_in = last_head_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      df_in        = df_ff;
      ds_in        = ds_ff;
      dh_in        = dh_ff;
      mid_in       = mid_ff;
      tmp_in       = tmp_ff;
      dxl_in       = dxl_ff;
      dyl_in       = dyl_ff;
      sh_in        = sh_ff;
      cm_in        = cm_ff;
      sm_in        = sm_ff;

      // each arithmetic state: issue once, then wait for the engine
      is_op     = (state_ff != ST_IDLE) && (state_ff != ST_DONE);
      fin       = run_ff && sts.done;
      run_in    = is_op && !fin;
      cmd.start = is_op && !run_ff;
      cmd.op    = OP_MUL;
      cmd.a     = '0;
      cmd.b     = '0;
      cmd.neg   = 1'b0;

      req_stall = (state_ff != ST_IDLE);
      accept    = req_valid && !req_stall;

      if (csr_we) begin
         priority case (csr_index)
            CSR_RADIUS:   radius_in   = csr_wdata;
            CSR_FWD_OFS:  fwd_ofs_in  = csr_wdata;
            CSR_SIDE_OFS: side_ofs_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.command) begin
                  // set pose: wheel history stays
                  gx_in        = req_data.pose_x;
                  gy_in        = req_data.pose_y;
                  last_head_in = req_data.heading;
                  state_in     = ST_DONE;
               end else begin
                  df_in        = req_data.forward_angle - last_fwd_ff;
                  ds_in        = req_data.sideways_angle - last_side_ff;
                  dh_in        = req_data.heading - last_head_ff;
                  // twice the mid-arc heading, 17 bits of a turn
                  mid_in       = {last_head_ff, 1'b0} + {dh_in[15], dh_in};
                  last_fwd_in  = req_data.forward_angle;
                  last_side_in = req_data.sideways_angle;
                  last_head_in = req_data.heading;
                  state_in     = (dh_in == 16'd0) ? ST_TXMUL : ST_ACOR;
               end
            end
         end

         // straight travel: round(|d|*r*pi/2^30), then *256/18000 rounded
         ST_TXMUL, ST_TYMUL: begin
            cmd.op = OP_MUL;
            cmd.a  = 72'(d_r);
            cmd.b  = PI_Q30;
            if (fin) begin
               tmp_in   = sts.res;
               state_in = (state_ff == ST_TXMUL) ? ST_TXDIV : ST_TYDIV;
            end
         end
         ST_TXDIV, ST_TYDIV: begin
            cmd.op  = OP_DIV;
            cmd.a   = {tmp_ff, 8'd0} + 72'(TRAVEL_HALF);
            cmd.b   = TRAVEL_DIV;
            cmd.neg = d_neg;
            if (fin) begin
               if (state_ff == ST_TXDIV) begin
                  dxl_in   = sts.res;
                  state_in = ST_TYMUL;
               end else begin
                  dyl_in   = sts.res;
                  state_in = ST_MCOR;
               end
            end
         end

         // arc: chord = (radius +/- offset) * 2*sin(dh/2)
         ST_ACOR: begin
            cmd.op = OP_COR;
            cmd.b  = {dh_ff[15], dh_ff, 15'd0};
            if (fin) begin
               sh_in    = sts.sin_q30;
               state_in = ST_AXDIV;
            end
         end
         ST_AXDIV, ST_AYDIV: begin
            // arc radius in Q16.16: |d|*r*2^24/(36000*|dh|), rounded
            cmd.op  = OP_DIV;
            cmd.a   = 72'({d_r, 24'd0}) + 72'(ud[31:1]);
            cmd.b   = ud;
            cmd.neg = d_neg ^ dh_ff[15];
            if (fin) begin
               if (state_ff == ST_AXDIV) begin
                  tmp_in   = sts.res + {44'd0, side_ofs_ff, 8'd0};
                  state_in = ST_AXMUL;
               end else begin
                  tmp_in   = sts.res - {44'd0, fwd_ofs_ff, 8'd0};
                  state_in = ST_AYMUL;
               end
            end
         end
         ST_AXMUL, ST_AYMUL: begin
            cmd.op  = OP_MUL;
            cmd.a   = 72'(tmp_mag);
            cmd.b   = sh2_mag;
            cmd.neg = tmp_ff[63] ^ sh_ff[33];
            if (fin) begin
               if (state_ff == ST_AXMUL) begin
                  dxl_in   = sts.res;
                  state_in = ST_AYDIV;
               end else begin
                  dyl_in   = sts.res;
                  state_in = ST_MCOR;
               end
            end
         end

         // rotate by the mid-arc heading
         ST_MCOR: begin
            cmd.op = OP_COR;
            cmd.b  = {mid_ff, 15'd0};
            if (fin) begin
               cm_in    = sts.cos_q30;
               sm_in    = sts.sin_q30;
               state_in = ST_G1;
            end
         end
         ST_G1: begin
            cmd.a   = 72'(dyl_mag);
            cmd.b   = sm_abs[31:0];
            cmd.neg = dyl_ff[63] ^ sm_ff[33];
            if (fin) begin
               gx_in    = gx_ff + sts.res[31:0];
               state_in = ST_G2;
            end
         end
         ST_G2: begin
            cmd.a   = 72'(dxl_mag);
            cmd.b   = cm_abs[31:0];
            cmd.neg = dxl_ff[63] ^ cm_ff[33];
            if (fin) begin
               gx_in    = gx_ff + sts.res[31:0];
               state_in = ST_G3;
            end
         end
         ST_G3: begin
            cmd.a   = 72'(dyl_mag);
            cmd.b   = cm_abs[31:0];
            cmd.neg = dyl_ff[63] ^ cm_ff[33];
            if (fin) begin
               gy_in    = gy_ff + sts.res[31:0];
               state_in = ST_G4;
            end
         end
         ST_G4: begin
            cmd.a   = 72'(dxl_mag);
            cmd.b   = sm_abs[31:0];
            cmd.neg = dxl_ff[63] ^ sm_ff[33];
            if (fin) begin
               gy_in    = gy_ff - sts.res[31:0];
               state_in = ST_DONE;
            end
         end

         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.position_x  = gx_ff;
               rsp_data_in.position_y  = gy_ff;
               rsp_data_in.heading_now = last_head_ff;
               state_in                = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= 12'd352;
         fwd_ofs_ff   <= 12'd800;
         side_ofs_ff  <= 12'd1370;
         last_fwd_ff  <= '0;
         last_side_ff <= '0;
         last_head_ff <= '0;
         gx_ff        <= '0;
         gy_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         radius_ff    <= radius_in;
         fwd_ofs_ff   <= fwd_ofs_in;
         side_ofs_ff  <= side_ofs_in;
         last_fwd_ff  <= last_fwd_in;
         last_side_ff <= last_side_in;
         last_head_ff <= last_head_in;
         gx_ff        <= gx_in;
         gy_ff        <= gy_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      df_ff       <= df_in;
      ds_ff       <= ds_in;
      dh_ff       <= dh_in;
      mid_ff      <= mid_in;
      tmp_ff      <= tmp_in;
      dxl_ff      <= dxl_in;
      dyl_ff      <= dyl_in;
      sh_ff       <= sh_in;
      cm_ff       <= cm_in;
      sm_ff       <= sm_in;
   end

endmodule

/* rtl/wipo_engine.sv */
// Shared serial arithmetic: shift-add multiplier with Q30 rounding, restoring divider,
// and an iterative CORDIC for sine/cosine. Depends on wipo_pkg.
module wipo_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  wipo_pkg::eng_cmd_type cmd,
   output wipo_pkg::eng_sts_type sts
);
   import wipo_pkg::*;

   localparam logic signed [33:0] QTR  = 34'sh0_4000_0000;
   localparam logic signed [33:0] HALF = 34'sh0_8000_0000;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   op_type           op_ff, op_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [95:0]      p_ff, p_in;
   logic [63:0]      a_ff, a_in;
   logic [71:0]      q_ff, q_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      d_ff, d_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic             flip_ff, flip_in;

   logic [64:0]        madd;
   logic [32:0]        trial;
   logic signed [33:0] xs, ys, at, z0;
   logic [31:0]        aq;
   logic [CNT_W-1:0]   last;
   logic [95:0]        prnd;
   logic [63:0]        mag;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      p_in    = p_ff;
      a_in    = a_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;

      madd  = {1'b0, p_ff[95:32]} + (p_ff[0] ? {1'b0, a_ff} : 65'd0);
      trial = {rem_ff, q_ff[71]};
      xs    = x_ff >>> cnt_ff[4:0];
      ys    = y_ff >>> cnt_ff[4:0];
      at    = {2'b00, ATAN_TURN[cnt_ff[4:0]]};

      // round the start angle to the CORDIC resolution
      aq = cmd.b + 32'(1 << (ANGLE_DROP - 1));
      aq = aq & ~32'((1 << ANGLE_DROP) - 1);
      z0 = {{2{aq[31]}}, aq};

      unique case (op_ff)
         OP_MUL:  last = CNT_W'(MUL_STEPS - 1);
         OP_DIV:  last = CNT_W'(DIV_STEPS - 1);
         default: last = CNT_W'(CORDIC_STEPS - 1);
      endcase

      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         neg_in  = cmd.neg;
         cnt_in  = '0;
         unique case (cmd.op)
            OP_MUL: begin
               p_in = {64'd0, cmd.b};
               a_in = cmd.a[63:0];
            end
            OP_DIV: begin
               q_in   = cmd.a;
               rem_in = '0;
               d_in   = cmd.b;
            end
            default: begin
               x_in    = {2'b00, GAIN_Q30};
               y_in    = '0;
               flip_in = 1'b0;
               z_in    = z0;
               if (z0 > QTR) begin
                  z_in    = z0 - HALF;
                  flip_in = 1'b1;
               end else if (z0 < -QTR) begin
                  z_in    = z0 + HALF;
                  flip_in = 1'b1;
               end
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               p_in = {madd, p_ff[31:1]};
            end
            OP_DIV: begin
               if (trial >= {1'b0, d_ff}) begin
                  rem_in = 32'(trial - {1'b0, d_ff});
                  q_in   = {q_ff[70:0], 1'b1};
               end else begin
                  rem_in = trial[31:0];
                  q_in   = {q_ff[70:0], 1'b0};
               end
            end
            default: begin
               if (!z_ff[33]) begin
                  x_in = x_ff - ys;
                  y_in = y_ff + xs;
                  z_in = z_ff - at;
               end else begin
                  x_in = x_ff + ys;
                  y_in = y_ff - xs;
                  z_in = z_ff + at;
               end
            end
         endcase
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      // results: Q30 product rounded half away from zero, quotient as is
      prnd = p_ff + 96'd536870912;
      mag  = (op_ff == OP_MUL) ? prnd[93:30] : q_ff[63:0];
      sts.done    = done_ff;
      sts.res     = neg_ff ? -$signed(mag) : $signed(mag);
      sts.cos_q30 = flip_ff ? -x_ff : x_ff;
      sts.sin_q30 = flip_ff ? -y_ff : y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      p_ff    <= p_in;
      a_ff    <= a_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      d_ff    <= d_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the wheel/heading pose tracker (wheel_imu_pose_odometry).
// Depends on rtl/wipo_pkg.sv for the payload types, register indexes and CORDIC table.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wipo_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;  // no register behind this index
   localparam longint CYCLE_LIMIT = 4000000;
   localparam int     HOLD_CYCLES = 3000;               // long receiver hold-off

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [11:0]          csr_wdata = '0;

   wheel_imu_pose_odometry i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Pose predictor: private copy of registers and tracker state
   // ---------------------------------------------------------------------------------
   logic [11:0] radius_q8, fwd_ofs_q8, side_ofs_q8;
   logic [31:0] prev_fwd_angle, prev_side_angle, pos_x, pos_y;
   logic [15:0] prev_heading;

   rsp_type pose_expected [$];
   int      error_count = 0;
   bit      idle_on = 1'b1;      // random bursts of idling on both channels
   bit      hold_go = 1'b0;      // asks the receiver for one long hold-off
   bit      hold_done = 1'b0;    // receiver has started that hold-off
   longint  cycle_count = 0;

   // round(a*s/2^30), half away from zero
   function automatic longint mul_q30(longint a, longint s);
      bit neg;
      longint unsigned ua, us, r;
      neg = (a < 0) != (s < 0);
      ua = (a < 0) ? -a : a;
      us = (s < 0) ? -s : s;
      r = (ua >> 30) * us + (((ua & 64'h3FFF_FFFF) * us + (64'd1 << 29)) >> 30);
      return neg ? -longint'(r) : longint'(r);
   endfunction

   // round(n/d), half away from zero
   function automatic longint div_round(longint n, longint unsigned d);
      longint unsigned un, q;
      un = (n < 0) ? -n : n;
      q = (un + d / 2) / d;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   // n*2^24/d with exact integer part, fraction rounded
   function automatic longint ratio_q24(longint n, longint d);
      bit neg;
      longint unsigned un, ud, q, rem, mag;
      neg = (n < 0) != (d < 0);
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = un / ud;
      rem = un % ud;
      mag = (q << 24) + ((rem << 24) + ud / 2) / ud;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint wheel_travel(longint delta);
      longint t;
      t = mul_q30(delta * longint'(radius_q8), longint'(PI_Q30));
      return div_round(t * 256, 18000);
   endfunction

   // CORDIC cosine/sine in Q30 of a binary angle (2^32 per turn)
   task automatic cordic_sincos(input logic [31:0] ang, output longint c, output longint s);
      logic [31:0] q;
      longint z, x, y, xs, ys;
      bit flip;
      q = (ang + (32'd1 << (ANGLE_DROP - 1))) & ~((32'd1 << ANGLE_DROP) - 32'd1);
      z = longint'($signed(q));
      x = longint'(GAIN_Q30);
      y = 0;
      flip = 1'b0;
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648;
         flip = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(ATAN_TURN[i]);
         end else begin
            x += ys; y -= xs; z += longint'(ATAN_TURN[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   // advance the predicted pose by one accepted transaction
   task automatic odometry_step(input req_type it, output rsp_type r);
      logic [31:0] df_u, ds_u;
      logic [15:0] dh_u;
      logic [16:0] dh17, mid2;
      longint df, ds, dxl, dyl, cm, sm, ch, sh, rx, ry, gx, gy;
      int dh;
      if (it.command) begin
         pos_x = it.pose_x;
         pos_y = it.pose_y;
         prev_heading = it.heading;
      end else begin
         df_u = it.forward_angle - prev_fwd_angle;
         ds_u = it.sideways_angle - prev_side_angle;
         df = longint'($signed(df_u));
         ds = longint'($signed(ds_u));
         dh_u = it.heading - prev_heading;
         dh = int'(dh_u);
         if (dh >= 32768) dh -= 65536;
         mid2 = 17'(int'(prev_heading) * 2 + dh);
         dh17 = 17'(dh);
         prev_fwd_angle = it.forward_angle;
         prev_side_angle = it.sideways_angle;
         prev_heading = it.heading;
         if (dh == 0) begin
            dxl = wheel_travel(ds);
            dyl = wheel_travel(df);
         end else begin
            cordic_sincos({dh17, 15'b0}, ch, sh);
            rx = ratio_q24(ds * longint'(radius_q8), 36000 * longint'(dh))
                 + longint'(side_ofs_q8) * 256;
            ry = ratio_q24(df * longint'(radius_q8), 36000 * longint'(dh))
                 - longint'(fwd_ofs_q8) * 256;
            dxl = mul_q30(rx, 2 * sh);
            dyl = mul_q30(ry, 2 * sh);
         end
         cordic_sincos({mid2, 15'b0}, cm, sm);
         gx = mul_q30(dyl, sm) + mul_q30(dxl, cm);
         gy = mul_q30(dyl, cm) - mul_q30(dxl, sm);
         pos_x = pos_x + gx[31:0];
         pos_y = pos_y + gy[31:0];
      end
      r.position_x = pos_x;
      r.position_y = pos_y;
      r.heading_now = prev_heading;
   endtask

   // ---------------------------------------------------------------------------------
   // Item builders; unused fields carry random bits so every input bit toggles
   // ---------------------------------------------------------------------------------
   function automatic req_type tick_item(logic [31:0] fa, logic [31:0] sa, logic [15:0] h);
      req_type it;
      it.command = 1'b0;
      it.forward_angle = fa;
      it.sideways_angle = sa;
      it.heading = h;
      it.pose_x = $urandom;
      it.pose_y = $urandom;
      return it;
   endfunction

   function automatic req_type pose_item(logic [31:0] x, logic [31:0] y, logic [15:0] h);
      req_type it;
      it.command = 1'b1;
      it.forward_angle = $urandom;
      it.sideways_angle = $urandom;
      it.heading = h;
      it.pose_x = x;
      it.pose_y = y;
      return it;
   endfunction

   // mostly realistic motion: small wheel deltas, small turns; some noise
   function automatic req_type motion_item();
      int pick, dh;
      pick = $urandom_range(0, 31);
      if (pick < 2)
         return pose_item($urandom, $urandom, 16'($urandom));
      if (pick < 4)
         return tick_item($urandom, $urandom, 16'($urandom));
      case ($urandom_range(0, 3))
         0:       dh = 0;
         1:       dh = int'($urandom_range(0, 60)) - 30;
         2:       dh = int'($urandom_range(0, 4000)) - 2000;
         default: dh = int'($urandom_range(0, 65535)) - 32768;
      endcase
      return tick_item(prev_fwd_angle + 32'(int'($urandom_range(0, 8000)) - 4000),
                       prev_side_angle + 32'(int'($urandom_range(0, 8000)) - 4000),
                       prev_heading + 16'(dh));
   endfunction

   // ---------------------------------------------------------------------------------
   // Sender: holds valid across back-to-back calls; drain_input drops it
   // ---------------------------------------------------------------------------------
   task automatic send_item(input req_type it);
      rsp_type r;
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      odometry_step(it, r);
      pose_expected.push_back(r);
   endtask

   task automatic drain_input();
      req_valid <= 1'b0;
      while (pose_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [11:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RADIUS:   radius_q8 = val;
         CSR_FWD_OFS:  fwd_ofs_q8 = val;
         CSR_SIDE_OFS: side_ofs_q8 = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic report(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   // ---------------------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold-off on request, result checking
   // ---------------------------------------------------------------------------------
   int stall_left = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_expected.size() == 0) begin
            report("unexpected transaction", longint'(rsp_data.position_x), longint'(0));
         end else begin
            want = pose_expected.pop_front();
            if (rsp_data.position_x !== want.position_x)
               report("position_x", longint'(rsp_data.position_x),
                      longint'(want.position_x));
            if (rsp_data.position_y !== want.position_y)
               report("position_y", longint'(rsp_data.position_y),
                      longint'(want.position_y));
            if (rsp_data.heading_now !== want.heading_now)
               report("heading_now", longint'(rsp_data.heading_now),
                      longint'(want.heading_now));
         end
      end
      // stall pattern for the next edge
      if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------
   // extremes of every field, both commands, heading wrap and full wheel swings
   task automatic test_directed();
      send_item(pose_item(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
      send_item(pose_item(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000));
      send_item(tick_item(32'h0, 32'h0, 16'h0));               // nothing moved
      send_item(tick_item(32'd1000, -32'sd500, 16'h0));         // straight, no turn
      send_item(tick_item(32'd1000 + 32'h7FFF_FFFF, 32'hFFFF_FE0C + 32'h7FFF_FFFF, 16'h0));
      send_item(tick_item(prev_fwd_angle + 32'h8000_0000,
                          prev_side_angle + 32'h8000_0000, 16'h0));  // most negative swing
      send_item(tick_item(prev_fwd_angle + 32'd3600, prev_side_angle, 16'h0001)); // tiny turn
      send_item(tick_item(prev_fwd_angle + 32'h7FFF_FFFF, prev_side_angle - 32'd77,
                          16'h0002));                            // huge travel, tiny turn
      send_item(tick_item(prev_fwd_angle + 32'd200, prev_side_angle + 32'd100,
                          prev_heading + 16'd32767));            // largest positive turn
      send_item(tick_item(prev_fwd_angle - 32'd200, prev_side_angle - 32'd100,
                          prev_heading + 16'd32768));            // half turn reads negative
      send_item(tick_item(prev_fwd_angle, prev_side_angle, prev_heading - 16'd1));
      send_item(tick_item(prev_fwd_angle + 32'd50, prev_side_angle + 32'd50, 16'hFFFF));
      send_item(tick_item(prev_fwd_angle + 32'd50, prev_side_angle, 16'h0000)); // wrap
      // set pose leaves wheel history alone; next tick measures from it
      send_item(pose_item(32'h0001_0000, 32'hFFFF_0000, 16'h4000));
      send_item(tick_item(prev_fwd_angle + 32'd9000, prev_side_angle + 32'd9000, 16'h4000));
      send_item(tick_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000));
      send_item(tick_item(32'h8000_0000, 32'h7FFF_FFFF, 16'hC000));
      drain_input();
   endtask

   // several register settings, extremes included, each followed by motion
   task automatic test_registers();
      logic [11:0] setting [6][3] = '{
         '{12'd4095, 12'd4095, 12'd4095},
         '{12'd1,    12'd0,    12'd0},
         '{12'd0,    12'd800,  12'd1370},   // zero radius: wheels contribute nothing
         '{12'd2730, 12'd1365, 12'd2730},
         '{12'd1365, 12'd2730, 12'd1365},
         '{12'd352,  12'd800,  12'd1370}
      };
      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_RADIUS, setting[p][0]);
         write_reg(CSR_FWD_OFS, setting[p][1]);
         write_reg(CSR_SIDE_OFS, setting[p][2]);
         write_reg(CSR_UNUSED, 12'($urandom));  // ignored by the block
         for (int n = 0; n < 30; n++) send_item(motion_item());
         drain_input();
      end
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) send_item(motion_item());
      drain_input();
   endtask

   // receiver holds off long enough for the tracker to fill and stall its input
   task automatic test_backpressure();
      hold_go = 1'b1;
      for (int n = 0; n < 40; n++) send_item(motion_item());
      drain_input();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      radius_q8 = 12'd352;
      fwd_ofs_q8 = 12'd800;
      side_ofs_q8 = 12'd1370;
      prev_fwd_angle = '0;
      prev_side_angle = '0;
      prev_heading = '0;
      pos_x = '0;
      pos_y = '0;
      @(posedge clock);
      test_directed();
      test_registers();
      test_random(1300);
      test_backpressure();
      idle_on = 1'b0;           // closing stretch with no idling on either side
      test_random(130);
      repeat (500) @(posedge clock);
      if (error_count == 0 && pose_expected.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
